/* src/vlt_pkg.sv */
// ----------------------------------------------------------------------------
// vlt_pkg: shared types and codes of the variable light table
// Field widths, command and status codes, controller states and the
// control and status words that pass between controller and datapath.
// ----------------------------------------------------------------------------
package vlt_pkg;

  localparam int CMD_W     = 3;
  localparam int SEG_W     = 15;
  localparam int SIDE_W    = 3;
  localparam int TEX_W     = 14;
  localparam int TEX_IDX_W = 13;
  localparam int MASK_W    = 32;
  localparam int TIME_W    = 16;
  localparam int SLOT_W    = 7;
  localparam int LEVEL_W   = 16;
  localparam int STATUS_W  = 3;
  localparam int COUNT_W   = 8;

  localparam logic [CMD_W-1:0] CMD_FIND     = 3'd0;
  localparam logic [CMD_W-1:0] CMD_ADD      = 3'd1;
  localparam logic [CMD_W-1:0] CMD_DEL_KEY  = 3'd2;
  localparam logic [CMD_W-1:0] CMD_DEL_SLOT = 3'd3;
  localparam logic [CMD_W-1:0] CMD_MAP_WR   = 3'd4;

  localparam logic [STATUS_W-1:0] ST_OK        = 3'd0;
  localparam logic [STATUS_W-1:0] ST_PRESENT   = 3'd1;
  localparam logic [STATUS_W-1:0] ST_FULL      = 3'd2;
  localparam logic [STATUS_W-1:0] ST_NO_LIGHT  = 3'd3;
  localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 3'd4;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_DECODE,
    S_SEARCH,
    S_LIGHT_B,
    S_LIGHT_O,
    S_LIGHT_CHK,
    S_MOVE_CHK,
    S_MOVE_WR,
    S_DONE
  } state_t;

  typedef enum logic [1:0] {
    WHERE_ZERO,
    WHERE_HIT,
    WHERE_SLOT,
    WHERE_COUNT
  } where_sel_t;

  typedef struct packed {
    logic [CMD_W-1:0]          command;
    logic [SEG_W-1:0]          segment;
    logic [SIDE_W-1:0]         side;
    logic [TEX_W-1:0]          base_texture;
    logic [TEX_W-1:0]          overlay_texture;
    logic [MASK_W-1:0]         blink_mask;
    logic signed [TIME_W-1:0]  blink_time;
    logic [SLOT_W-1:0]         slot;
    logic [LEVEL_W-1:0]        light_level;
  } item_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [SLOT_W-1:0]   found_slot;
    logic [COUNT_W-1:0]  entry_count;
  } result_t;

  typedef struct packed {
    logic                load;
    logic                clr_wr;
    logic                scan;
    logic                map_rd_base;
    logic                map_rd_ovl;
    logic                map_wr;
    logic                add_commit;
    logic                rm_start;
    logic                rm_from_slot;
    logic                move_rd;
    logic                move_wr;
    logic                res_load;
    logic [STATUS_W-1:0] res_status;
    where_sel_t          res_where;
    logic                out_push;
  } ctl_t;

  typedef struct packed {
    logic [CMD_W-1:0] cmd;
    logic             clear_last;
    logic             hit;
    logic             miss;
    logic             full;
    logic             lit;
    logic             slot_ok;
    logic             move_needed;
    logic             out_free;
  } sts_t;

endpackage

/* src/vlt_if.sv */
// ----------------------------------------------------------------------------
// vlt_if: channel interfaces of the variable light table
// One interface for the command channel and one for the result channel,
// each with valid, ready and the payload fields.
// ----------------------------------------------------------------------------
interface vlt_in_if;
  import vlt_pkg::*;

  logic                     valid;
  logic                     ready;
  logic [CMD_W-1:0]         command;
  logic [SEG_W-1:0]         segment;
  logic [SIDE_W-1:0]        side;
  logic [TEX_W-1:0]         base_texture;
  logic [TEX_W-1:0]         overlay_texture;
  logic [MASK_W-1:0]        blink_mask;
  logic signed [TIME_W-1:0] blink_time;
  logic [SLOT_W-1:0]        slot;
  logic [LEVEL_W-1:0]       light_level;

  modport source (
    output valid, command, segment, side, base_texture, overlay_texture,
           blink_mask, blink_time, slot, light_level,
    input  ready
  );

  modport sink (
    input  valid, command, segment, side, base_texture, overlay_texture,
           blink_mask, blink_time, slot, light_level,
    output ready
  );
endinterface

interface vlt_out_if;
  import vlt_pkg::*;

  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic [SLOT_W-1:0]   found_slot;
  logic [COUNT_W-1:0]  entry_count;

  modport source (
    output valid, status, found_slot, entry_count,
    input  ready
  );

  modport sink (
    input  valid, status, found_slot, entry_count,
    output ready
  );
endinterface

/* src/variable_light_table_top.sv */
// ----------------------------------------------------------------------------
// variable_light_table_top: variable light table
// Table of blinking-light entries keyed by segment and side, with a
// per-texture light map, driven by find, add, delete and map-write commands.
// ----------------------------------------------------------------------------
// Each command word yields exactly one result word. After reset the light
// map is cleared one entry per cycle, so in_ready stays low until every
// entry has been cleared. Find, add and delete by key search the table
// through its single read port, one slot per cycle; an add then reads the
// light map for its base and overlay textures, and a delete may move the
// last entry into the freed slot.
// The block works on one command at a time; a new command is taken while
// the previous result still waits in the output register.
module variable_light_table_top #(
  parameter int MAX_ENTRIES     = 128,
  parameter int LIGHT_MAP_DEPTH = 8192
) (
  input logic       clk,
  input logic       rst_n,
  vlt_in_if.sink    in_ch,
  vlt_out_if.source out_ch
);
  import vlt_pkg::*;

  item_t   in_item;
  result_t out_res;
  ctl_t    ctl;
  sts_t    sts;
  logic    in_ready;
  logic    out_valid;

  assign in_item.command         = in_ch.command;
  assign in_item.segment         = in_ch.segment;
  assign in_item.side            = in_ch.side;
  assign in_item.base_texture    = in_ch.base_texture;
  assign in_item.overlay_texture = in_ch.overlay_texture;
  assign in_item.blink_mask      = in_ch.blink_mask;
  assign in_item.blink_time      = in_ch.blink_time;
  assign in_item.slot            = in_ch.slot;
  assign in_item.light_level     = in_ch.light_level;
  assign in_ch.ready             = in_ready;

  assign out_ch.valid       = out_valid;
  assign out_ch.status      = out_res.status;
  assign out_ch.found_slot  = out_res.found_slot;
  assign out_ch.entry_count = out_res.entry_count;

  vlt_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ready),
    .sts      (sts),
    .ctl      (ctl)
  );

  vlt_dp #(
    .MAX_ENTRIES     (MAX_ENTRIES),
    .LIGHT_MAP_DEPTH (LIGHT_MAP_DEPTH)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_item   (in_item),
    .ctl       (ctl),
    .sts       (sts),
    .out_valid (out_valid),
    .out_ready (out_ch.ready),
    .out_res   (out_res)
  );

endmodule

/* src/vlt_ctrl.sv */
// ----------------------------------------------------------------------------
// vlt_ctrl: controller of the variable light table
// State machine that sequences the map clearing pass, the key search, the
// light check, the entry move on delete and the hand-off of each result.
// ----------------------------------------------------------------------------
module vlt_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  vlt_pkg::sts_t sts,
  output vlt_pkg::ctl_t ctl
);
  import vlt_pkg::*;

  state_t state_r;
  state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt      = state_r;
    ctl            = '0;
    ctl.res_status = ST_OK;
    ctl.res_where  = WHERE_ZERO;
    in_ready       = 1'b0;
    unique case (state_r)
      S_CLEAR: begin
        ctl.clr_wr = 1'b1;
        if (sts.clear_last) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          ctl.load  = 1'b1;
          state_nxt = S_DECODE;
        end
      end
      S_DECODE: begin
        unique case (sts.cmd) inside
          CMD_FIND, CMD_ADD, CMD_DEL_KEY: begin
            state_nxt = S_SEARCH;
          end
          CMD_DEL_SLOT: begin
            ctl.res_load = 1'b1;
            if (sts.slot_ok) begin
              ctl.rm_start     = 1'b1;
              ctl.rm_from_slot = 1'b1;
              ctl.res_where    = WHERE_SLOT;
              state_nxt        = S_MOVE_CHK;
            end else begin
              ctl.res_status = ST_NOT_FOUND;
              state_nxt      = S_DONE;
            end
          end
          CMD_MAP_WR: begin
            ctl.map_wr   = 1'b1;
            ctl.res_load = 1'b1;
            state_nxt    = S_DONE;
          end
          default: begin
            ctl.res_load = 1'b1;
            state_nxt    = S_DONE;
          end
        endcase
      end
      S_SEARCH: begin
        ctl.scan = 1'b1;
        if (sts.hit) begin
          ctl.res_load = 1'b1;
          unique case (sts.cmd)
            CMD_ADD: begin
              ctl.res_status = ST_PRESENT;
              state_nxt      = S_DONE;
            end
            CMD_DEL_KEY: begin
              ctl.rm_start  = 1'b1;
              ctl.res_where = WHERE_HIT;
              state_nxt     = S_MOVE_CHK;
            end
            default: begin
              ctl.res_where = WHERE_HIT;
              state_nxt     = S_DONE;
            end
          endcase
        end else if (sts.miss) begin
          if (sts.cmd == CMD_ADD) begin
            if (sts.full) begin
              ctl.res_load   = 1'b1;
              ctl.res_status = ST_FULL;
              state_nxt      = S_DONE;
            end else begin
              state_nxt = S_LIGHT_B;
            end
          end else begin
            ctl.res_load   = 1'b1;
            ctl.res_status = ST_NOT_FOUND;
            state_nxt      = S_DONE;
          end
        end
      end
      S_LIGHT_B: begin
        ctl.map_rd_base = 1'b1;
        state_nxt       = S_LIGHT_O;
      end
      S_LIGHT_O: begin
        ctl.map_rd_ovl = 1'b1;
        state_nxt      = S_LIGHT_CHK;
      end
      S_LIGHT_CHK: begin
        ctl.res_load = 1'b1;
        if (sts.lit) begin
          ctl.add_commit = 1'b1;
          ctl.res_where  = WHERE_COUNT;
        end else begin
          ctl.res_status = ST_NO_LIGHT;
        end
        state_nxt = S_DONE;
      end
      S_MOVE_CHK: begin
        if (sts.move_needed) begin
          ctl.move_rd = 1'b1;
          state_nxt   = S_MOVE_WR;
        end else begin
          state_nxt = S_DONE;
        end
      end
      S_MOVE_WR: begin
        ctl.move_wr = 1'b1;
        state_nxt   = S_DONE;
      end
      S_DONE: begin
        if (sts.out_free) begin
          ctl.out_push = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

endmodule

/* src/vlt_dp.sv */
// ----------------------------------------------------------------------------
// vlt_dp: datapath of the variable light table
// Holds the entry table and the light map as memories, the entry count,
// the search counter, the result registers and the output register.
// ----------------------------------------------------------------------------
module vlt_dp #(
  parameter int MAX_ENTRIES     = 128,
  parameter int LIGHT_MAP_DEPTH = 8192
) (
  input  logic             clk,
  input  logic             rst_n,
  input  vlt_pkg::item_t   in_item,
  input  vlt_pkg::ctl_t    ctl,
  output vlt_pkg::sts_t    sts,
  output logic             out_valid,
  input  logic             out_ready,
  output vlt_pkg::result_t out_res
);
  import vlt_pkg::*;

  localparam int IDX_W  = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int CNT_W  = $clog2(MAX_ENTRIES + 1);
  localparam int MAP_AW = $clog2(LIGHT_MAP_DEPTH);

  typedef struct packed {
    logic [SEG_W-1:0]  seg;
    logic [SIDE_W-1:0] side;
    logic [MASK_W-1:0] mask;
    logic [TIME_W-1:0] timer;
    logic [TIME_W-1:0] delay;
  } entry_t;

  entry_t             tbl_mem [MAX_ENTRIES];
  entry_t             tbl_q;
  logic [LEVEL_W-1:0] map_mem [LIGHT_MAP_DEPTH];
  logic [LEVEL_W-1:0] map_q;

  item_t               item_r;
  logic [CNT_W-1:0]    count_r;
  logic [CNT_W-1:0]    scan_idx_r;
  logic [CNT_W-1:0]    scan_idx_nxt;
  logic                rd_vld_r;
  logic                rd_vld_nxt;
  logic [IDX_W-1:0]    rd_idx_r;
  logic [IDX_W-1:0]    rd_idx_nxt;
  logic [IDX_W-1:0]    victim_r;
  logic                base_lit_r;
  logic [MAP_AW-1:0]   clr_cnt_r;
  logic [STATUS_W-1:0] res_status_r;
  logic [SLOT_W-1:0]   res_where_r;
  logic                out_valid_r;
  result_t             out_res_r;

  logic              scan_more;
  logic              tbl_re;
  logic [IDX_W-1:0]  tbl_raddr;
  logic              tbl_we;
  logic [IDX_W-1:0]  tbl_waddr;
  entry_t            tbl_wdata;
  logic              map_re;
  logic [MAP_AW-1:0] map_raddr;
  logic              map_we;
  logic [MAP_AW-1:0] map_waddr;
  logic [LEVEL_W-1:0] map_wdata;
  logic              base_in_range;
  logic              ovl_in_range;
  logic              slot_in_range;
  logic              map_nonzero;

  assign scan_more     = scan_idx_r < count_r;
  assign base_in_range = int'(item_r.base_texture[TEX_IDX_W-1:0]) < LIGHT_MAP_DEPTH;
  assign ovl_in_range  = int'(item_r.overlay_texture[TEX_IDX_W-1:0]) < LIGHT_MAP_DEPTH;
  assign slot_in_range = int'(item_r.slot) < LIGHT_MAP_DEPTH;
  assign map_nonzero   = map_q != '0;

  always_comb begin
    scan_idx_nxt = scan_idx_r;
    rd_vld_nxt   = 1'b0;
    rd_idx_nxt   = rd_idx_r;
    tbl_re       = 1'b0;
    tbl_raddr    = scan_idx_r[IDX_W-1:0];
    if (ctl.load) begin
      scan_idx_nxt = '0;
    end else if (ctl.scan && scan_more) begin
      tbl_re       = 1'b1;
      scan_idx_nxt = CNT_W'(scan_idx_r + 1'b1);
      rd_vld_nxt   = 1'b1;
      rd_idx_nxt   = scan_idx_r[IDX_W-1:0];
    end
    if (ctl.move_rd) begin
      tbl_re    = 1'b1;
      tbl_raddr = count_r[IDX_W-1:0];
    end
  end

  always_comb begin
    tbl_we          = ctl.add_commit | ctl.move_wr;
    tbl_waddr       = count_r[IDX_W-1:0];
    tbl_wdata.seg   = item_r.segment;
    tbl_wdata.side  = item_r.side;
    tbl_wdata.mask  = item_r.blink_mask;
    tbl_wdata.timer = item_r.blink_time;
    tbl_wdata.delay = item_r.blink_time;
    if (ctl.move_wr) begin
      tbl_waddr = victim_r;
      tbl_wdata = tbl_q;
    end
  end

  always_comb begin
    map_re    = ctl.map_rd_base | ctl.map_rd_ovl;
    map_raddr = ctl.map_rd_ovl ? MAP_AW'(item_r.overlay_texture[TEX_IDX_W-1:0])
                               : MAP_AW'(item_r.base_texture[TEX_IDX_W-1:0]);
    map_we    = ctl.clr_wr | (ctl.map_wr & slot_in_range);
    map_waddr = ctl.clr_wr ? clr_cnt_r : MAP_AW'(item_r.slot);
    map_wdata = ctl.clr_wr ? '0 : item_r.light_level;
  end

  always_ff @(posedge clk) begin
    if (tbl_we) begin
      tbl_mem[tbl_waddr] <= tbl_wdata;
    end
    if (tbl_re) begin
      tbl_q <= tbl_mem[tbl_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (map_we) begin
      map_mem[map_waddr] <= map_wdata;
    end
    if (map_re) begin
      map_q <= map_mem[map_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      clr_cnt_r   <= '0;
      rd_vld_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      rd_vld_r <= rd_vld_nxt;
      if (ctl.clr_wr) begin
        clr_cnt_r <= MAP_AW'(clr_cnt_r + 1'b1);
      end
      if (ctl.add_commit) begin
        count_r <= CNT_W'(count_r + 1'b1);
      end else if (ctl.rm_start) begin
        count_r <= CNT_W'(count_r - 1'b1);
      end
      if (ctl.out_push) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    scan_idx_r <= scan_idx_nxt;
    rd_idx_r   <= rd_idx_nxt;
    if (ctl.load) begin
      item_r <= in_item;
    end
    if (ctl.rm_start) begin
      victim_r <= ctl.rm_from_slot ? IDX_W'(item_r.slot) : rd_idx_r;
    end
    if (ctl.map_rd_ovl) begin
      base_lit_r <= base_in_range & map_nonzero;
    end
    if (ctl.res_load) begin
      res_status_r <= ctl.res_status;
      case (ctl.res_where)
        WHERE_HIT:   res_where_r <= SLOT_W'(rd_idx_r);
        WHERE_SLOT:  res_where_r <= item_r.slot;
        WHERE_COUNT: res_where_r <= SLOT_W'(count_r);
        default:     res_where_r <= '0;
      endcase
    end
    if (ctl.out_push) begin
      out_res_r.status      <= res_status_r;
      out_res_r.found_slot  <= res_where_r;
      out_res_r.entry_count <= COUNT_W'(count_r);
    end
  end

  assign sts.cmd         = item_r.command;
  assign sts.clear_last  = clr_cnt_r == MAP_AW'(LIGHT_MAP_DEPTH - 1);
  assign sts.hit         = rd_vld_r && (tbl_q.seg == item_r.segment)
                           && (tbl_q.side == item_r.side);
  assign sts.miss        = !rd_vld_r && !scan_more;
  assign sts.full        = count_r >= CNT_W'(MAX_ENTRIES);
  assign sts.lit         = base_lit_r | (ovl_in_range & map_nonzero);
  assign sts.slot_ok     = int'(item_r.slot) < int'(count_r);
  assign sts.move_needed = CNT_W'(victim_r) < count_r;
  assign sts.out_free    = !out_valid_r || out_ready;

  assign out_valid = out_valid_r;
  assign out_res   = out_res_r;

endmodule

/* src/vlt_checker.sv */
// ----------------------------------------------------------------------------
// vlt_checker: port-level checks of the variable light table
// Concurrent assertions on the channel ports, attached to the top level.
// ----------------------------------------------------------------------------
module vlt_checker #(
  parameter int MAX_ENTRIES = 128
) (
  input logic                         clk,
  input logic                         rst_n,
  input logic                         in_valid,
  input logic                         in_ready,
  input logic                         out_valid,
  input logic                         out_ready,
  input logic [vlt_pkg::STATUS_W-1:0] out_status,
  input logic [vlt_pkg::SLOT_W-1:0]   out_found_slot,
  input logic [vlt_pkg::COUNT_W-1:0]  out_entry_count
);
  import vlt_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_status)
      && $stable(out_found_slot) && $stable(out_entry_count))
    else $error("Result word changed while stalled.");

  a_refused_slot_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != ST_OK |-> out_found_slot == '0)
    else $error("Refused command reports a nonzero slot.");

  a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == ST_FULL |-> out_entry_count == COUNT_W'(MAX_ENTRIES))
    else $error("Table full reported with a count below capacity.");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("Second command word taken while one is in work.");

  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_valid && !in_ready)
    else $error("Block not quiet after reset.");

endmodule

bind variable_light_table_top vlt_checker #(
  .MAX_ENTRIES (MAX_ENTRIES)
) u_vlt_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_valid        (in_ch.valid),
  .in_ready        (in_ch.ready),
  .out_valid       (out_ch.valid),
  .out_ready       (out_ch.ready),
  .out_status      (out_ch.status),
  .out_found_slot  (out_ch.found_slot),
  .out_entry_count (out_ch.entry_count)
);

/* sim/vlt_checker.sv */
// ----------------------------------------------------------------------------
// vlt_result_checker: result checker for the variable light table
// Watches the command and result channels, keeps its own copy of the entry
// table and the light map, works out the answer to every accepted command
// word and compares each accepted result word with the oldest answer owed.
// ----------------------------------------------------------------------------
module vlt_result_checker #(
  parameter int MAX_ENTRIES     = 128,
  parameter int LIGHT_MAP_DEPTH = 8192
) (
  input  logic clk,
  input  logic rst_n,
  vlt_in_if    in_mon,
  vlt_out_if   out_mon,
  output int   fail_count,
  output int   words_in,
  output int   pending,
  output int   peak_fill,
  output int   full_refusals,
  output int   slot_moves
);
  timeunit 1ns;
  timeprecision 1ps;

  import vlt_pkg::*;

  logic [SEG_W-1:0]   tbl_segment [MAX_ENTRIES];
  logic [SIDE_W-1:0]  tbl_side    [MAX_ENTRIES];
  logic [MASK_W-1:0]  tbl_mask    [MAX_ENTRIES];
  logic [TIME_W-1:0]  tbl_timer   [MAX_ENTRIES];
  logic [TIME_W-1:0]  tbl_delay   [MAX_ENTRIES];
  logic [LEVEL_W-1:0] light_map   [LIGHT_MAP_DEPTH];
  int                 used;
  int                 words_out;
  result_t            owed_answers [$];

  function automatic int slot_of_key(logic [SEG_W-1:0] seg, logic [SIDE_W-1:0] sd);
    for (int i = 0; i < used && i < MAX_ENTRIES; i++) begin
      if (tbl_segment[i] == seg && tbl_side[i] == sd) return i;
    end
    return -1;
  endfunction

  function automatic bit texture_lit(logic [TEX_W-1:0] tex);
    int idx;
    idx = int'(tex[TEX_IDX_W-1:0]);
    if (idx >= LIGHT_MAP_DEPTH) return 1'b0;
    return light_map[idx] != '0;
  endfunction

  function automatic void free_slot(int s);
    used--;
    if (s < used && used < MAX_ENTRIES) begin
      tbl_segment[s] = tbl_segment[used];
      tbl_side[s]    = tbl_side[used];
      tbl_mask[s]    = tbl_mask[used];
      tbl_timer[s]   = tbl_timer[used];
      tbl_delay[s]   = tbl_delay[used];
      slot_moves++;
    end
  endfunction

  function automatic result_t answer_of(item_t w);
    result_t r;
    int      hit;
    int      where;
    r.status = ST_OK;
    where    = 0;
    case (w.command)
      CMD_FIND: begin
        hit = slot_of_key(w.segment, w.side);
        if (hit < 0) r.status = ST_NOT_FOUND;
        else where = hit;
      end
      CMD_ADD: begin
        if (slot_of_key(w.segment, w.side) >= 0) begin
          r.status = ST_PRESENT;
        end else if (used >= MAX_ENTRIES) begin
          r.status = ST_FULL;
          full_refusals++;
        end else if (!texture_lit(w.base_texture) && !texture_lit(w.overlay_texture)) begin
          r.status = ST_NO_LIGHT;
        end else begin
          where              = used;
          tbl_segment[where] = w.segment;
          tbl_side[where]    = w.side;
          tbl_mask[where]    = w.blink_mask;
          tbl_timer[where]   = w.blink_time;
          tbl_delay[where]   = w.blink_time;
          used++;
          if (used > peak_fill) peak_fill = used;
        end
      end
      CMD_DEL_KEY: begin
        hit = slot_of_key(w.segment, w.side);
        if (hit < 0) begin
          r.status = ST_NOT_FOUND;
        end else begin
          where = hit;
          free_slot(where);
        end
      end
      CMD_DEL_SLOT: begin
        if (int'(w.slot) >= used) begin
          r.status = ST_NOT_FOUND;
        end else begin
          where = int'(w.slot);
          free_slot(where);
        end
      end
      CMD_MAP_WR: begin
        if (int'(w.slot) < LIGHT_MAP_DEPTH) light_map[w.slot] = w.light_level;
      end
      default: ;
    endcase
    r.found_slot  = where[SLOT_W-1:0];
    r.entry_count = used[COUNT_W-1:0];
    return r;
  endfunction

  function automatic void check_field(string name, int want, int got);
    if (want != got) begin
      $display("%0t ns: result word %0d, %s expected %0d, actual %0d",
               $time, words_out, name, want, got);
      fail_count++;
    end
  endfunction

  always @(posedge clk) begin
    result_t want;
    item_t   word;
    if (!rst_n) begin
      used = 0;
      foreach (light_map[i]) light_map[i] = '0;
      owed_answers.delete();
    end else begin
      if (out_mon.valid && out_mon.ready) begin
        if (owed_answers.size() == 0) begin
          $display("%0t ns: result word %0d, expected none, actual status %0d slot %0d count %0d",
                   $time, words_out, out_mon.status, out_mon.found_slot,
                   out_mon.entry_count);
          fail_count++;
        end else begin
          want = owed_answers.pop_front();
          check_field("status", int'(want.status), int'(out_mon.status));
          check_field("found_slot", int'(want.found_slot), int'(out_mon.found_slot));
          check_field("entry_count", int'(want.entry_count), int'(out_mon.entry_count));
        end
        words_out++;
      end
      if (in_mon.valid && in_mon.ready) begin
        word.command         = in_mon.command;
        word.segment         = in_mon.segment;
        word.side            = in_mon.side;
        word.base_texture    = in_mon.base_texture;
        word.overlay_texture = in_mon.overlay_texture;
        word.blink_mask      = in_mon.blink_mask;
        word.blink_time      = in_mon.blink_time;
        word.slot            = in_mon.slot;
        word.light_level     = in_mon.light_level;
        owed_answers.push_back(answer_of(word));
        words_in++;
      end
    end
    pending = owed_answers.size();
  end

endmodule

/* sim/tb_top.sv */
// ----------------------------------------------------------------------------
// tb_top: testbench of the variable light table
// Drives a directed opening and then blocks of random command words that
// fill, churn and drain the entry table and rewrite the light map, with
// random gaps on both channels and one long result stall; the checker
// beside the block predicts and compares every result word.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import vlt_pkg::*;

  localparam int    MAX_ENTRIES     = 128;
  localparam int    LIGHT_MAP_DEPTH = 8192;
  localparam int    RANDOM_WORDS    = 1650;
  localparam int    STALL_AT        = 500;
  localparam int    STALL_CYCLES    = 1000;
  localparam longint LIMIT_NS       = 18_000_000;

  typedef enum int {MIX_FILL, MIX_BALANCED, MIX_DRAIN, MIX_NOISE} mix_t;

  logic clk = 1'b0;
  logic rst_n;

  vlt_in_if  in_ch ();
  vlt_out_if out_ch ();

  int fail_count;
  int words_in;
  int pending;
  int peak_fill;
  int full_refusals;
  int slot_moves;
  int words_sent;
  int defined_words;
  int results_taken;
  int fill_seq = 32;
  bit send_quiet;
  bit take_quiet;

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  variable_light_table_top #(
    .MAX_ENTRIES    (MAX_ENTRIES),
    .LIGHT_MAP_DEPTH(LIGHT_MAP_DEPTH)
  ) dut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .out_ch(out_ch)
  );

  vlt_result_checker #(
    .MAX_ENTRIES    (MAX_ENTRIES),
    .LIGHT_MAP_DEPTH(LIGHT_MAP_DEPTH)
  ) answer_check (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_mon       (in_ch),
    .out_mon      (out_ch),
    .fail_count   (fail_count),
    .words_in     (words_in),
    .pending      (pending),
    .peak_fill    (peak_fill),
    .full_refusals(full_refusals),
    .slot_moves   (slot_moves)
  );

  function automatic item_t make_word(logic [CMD_W-1:0] cmd, logic [SEG_W-1:0] seg,
                                      logic [SIDE_W-1:0] sd, logic [TEX_W-1:0] btex,
                                      logic [TEX_W-1:0] otex, logic [MASK_W-1:0] mask,
                                      logic [TIME_W-1:0] btime, logic [SLOT_W-1:0] slot,
                                      logic [LEVEL_W-1:0] level);
    item_t w;
    w.command         = cmd;
    w.segment         = seg;
    w.side            = sd;
    w.base_texture    = btex;
    w.overlay_texture = otex;
    w.blink_mask      = mask;
    w.blink_time      = btime;
    w.slot            = slot;
    w.light_level     = level;
    return w;
  endfunction

  function automatic logic [SEG_W-1:0] pool_segment();
    logic [SEG_W-1:0] n;
    n = SEG_W'($urandom_range(0, 31));
    return ($urandom_range(0, 1) != 0) ? n : 15'h7fff - n;
  endfunction

  function automatic logic [TEX_W-1:0] lit_texture(bit hot);
    logic [6:0] addr;
    addr = hot ? 7'($urandom_range(0, 15)) : 7'($urandom_range(0, 127));
    return {1'($urandom_range(0, 1)), 6'd0, addr};
  endfunction

  function automatic item_t random_word(mix_t kind);
    item_t w;
    int    pick;
    w.command         = CMD_FIND;
    w.segment         = pool_segment();
    w.side            = SIDE_W'($urandom_range(0, 7));
    w.base_texture    = ($urandom_range(0, 2) == 0) ? TEX_W'($urandom)
                                                    : lit_texture(kind == MIX_FILL);
    w.overlay_texture = ($urandom_range(0, 1) == 0) ? TEX_W'($urandom)
                                                    : lit_texture(kind == MIX_FILL);
    w.blink_mask      = $urandom;
    w.blink_time      = TIME_W'($urandom);
    w.slot            = ($urandom_range(0, 1) == 0) ? SLOT_W'($urandom_range(0, 15))
                                                    : SLOT_W'($urandom);
    w.light_level     = ($urandom_range(0, 3) == 0) ? '0 : LEVEL_W'($urandom);
    pick = $urandom_range(0, 99);
    case (kind)
      MIX_FILL: begin
        if (pick < 88) begin
          w.command = CMD_ADD;
          fill_seq++;
          w.segment = SEG_W'(fill_seq);
        end else if (pick < 95) begin
          w.command     = CMD_MAP_WR;
          w.slot        = SLOT_W'($urandom_range(0, 15));
          w.light_level = LEVEL_W'($urandom_range(1, 65535));
        end
      end
      MIX_BALANCED: begin
        if (pick < 30) w.command = CMD_FIND;
        else if (pick < 60) w.command = CMD_ADD;
        else if (pick < 75) w.command = CMD_DEL_KEY;
        else if (pick < 88) w.command = CMD_DEL_SLOT;
        else w.command = CMD_MAP_WR;
      end
      MIX_DRAIN: begin
        if (pick < 20) w.command = CMD_FIND;
        else if (pick < 30) w.command = CMD_ADD;
        else if (pick < 65) w.command = CMD_DEL_KEY;
        else if (pick < 95) w.command = CMD_DEL_SLOT;
        else w.command = CMD_MAP_WR;
      end
      default: begin
        w.command         = CMD_W'($urandom);
        w.segment         = SEG_W'($urandom);
        w.base_texture    = TEX_W'($urandom);
        w.overlay_texture = TEX_W'($urandom);
        w.light_level     = LEVEL_W'($urandom);
      end
    endcase
    return w;
  endfunction

  task automatic send_word(item_t w);
    int gap;
    if ($urandom_range(0, 39) == 0) send_quiet = !send_quiet;
    gap = send_quiet ? 0 : $urandom_range(0, 13);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.command         <= w.command;
    in_ch.segment         <= w.segment;
    in_ch.side            <= w.side;
    in_ch.base_texture    <= w.base_texture;
    in_ch.overlay_texture <= w.overlay_texture;
    in_ch.blink_mask      <= w.blink_mask;
    in_ch.blink_time      <= w.blink_time;
    in_ch.slot            <= w.slot;
    in_ch.light_level     <= w.light_level;
    in_ch.valid           <= 1'b1;
    do @(posedge clk); while (!in_ch.ready);
    words_sent++;
    if (w.command <= CMD_MAP_WR) defined_words++;
  endtask

  initial begin : result_sink
    int gap;
    out_ch.ready <= 1'b0;
    @(posedge clk);
    forever begin
      if ($urandom_range(0, 39) == 0) take_quiet = !take_quiet;
      gap = take_quiet ? 0 : $urandom_range(0, 13);
      if (results_taken == STALL_AT) gap = STALL_CYCLES;
      if (gap > 0) begin
        out_ch.ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (!(out_ch.valid && rst_n));
      results_taken++;
    end
  end

  initial begin : stimulus
    mix_t kind;
    int   block_len;
    int   pick;
    int   random_count;
    rst_n                 <= 1'b0;
    in_ch.valid           <= 1'b0;
    in_ch.command         <= '0;
    in_ch.segment         <= '0;
    in_ch.side            <= '0;
    in_ch.base_texture    <= '0;
    in_ch.overlay_texture <= '0;
    in_ch.blink_mask      <= '0;
    in_ch.blink_time      <= '0;
    in_ch.slot            <= '0;
    in_ch.light_level     <= '0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // Empty table, dark light map.
    send_word(make_word(CMD_FIND, 15'h7fff, 3'd7, '0, '0, '0, '0, '0, '0));
    send_word(make_word(CMD_DEL_KEY, 15'h7fff, 3'd7, '0, '0, '0, '0, '0, '0));
    send_word(make_word(CMD_DEL_SLOT, '0, '0, '0, '0, '0, '0, 7'd0, '0));
    send_word(make_word(CMD_ADD, 15'd9, 3'd2, 14'h0000, 14'h3fff, '1, '0, '0, '0));
    send_word(make_word(CMD_MAP_WR, '0, '0, '0, '0, '0, '0, 7'd127, 16'hffff));
    send_word(make_word(CMD_MAP_WR, '0, '0, '0, '0, '0, '0, 7'd0, 16'h0001));
    // Lit only through the overlay, whose upper bit is masked off.
    send_word(make_word(CMD_ADD, 15'h7fff, 3'd7, 14'h3fff, 14'h207f, 32'hffff_ffff,
                        16'h8000, 7'd127, 16'hffff));
    send_word(make_word(CMD_ADD, 15'h0000, 3'd0, 14'h0000, 14'h3fff, 32'h0000_0000,
                        16'h7fff, '0, '0));
    send_word(make_word(CMD_ADD, 15'h7fff, 3'd7, 14'h0000, 14'h0000, '0, '0, '0, '0));
    send_word(make_word(CMD_FIND, 15'h7fff, 3'd6, '0, '0, '0, '0, '0, '0));
    send_word(make_word(CMD_FIND, 15'h0000, 3'd0, '0, '0, '0, '0, '0, '0));
    send_word(make_word(CMD_ADD, 15'd1, 3'd5, 14'h2000, 14'h1fff, 32'h5a5a_a5a5,
                        16'hffff, '0, '0));
    send_word(make_word(CMD_DEL_SLOT, '0, '0, '0, '0, '0, '0, 7'd127, '0));
    send_word(make_word(CMD_DEL_SLOT, '0, '0, '0, '0, '0, '0, 7'd3, '0));
    send_word(make_word(CMD_DEL_SLOT, '0, '0, '0, '0, '0, '0, 7'd2, '0));
    send_word(make_word(CMD_DEL_KEY, 15'h7fff, 3'd7, '0, '0, '0, '0, '0, '0));
    send_word(make_word(CMD_FIND, 15'h0000, 3'd0, '0, '0, '0, '0, '0, '0));
    send_word(make_word(3'd5, 15'h7fff, 3'd7, 14'h3fff, 14'h3fff, '1, '1, 7'd127, '1));
    send_word(make_word(3'd6, 15'h0000, 3'd0, '0, '0, '0, '0, 7'd0, '0));
    send_word(make_word(3'd7, 15'h2aaa, 3'd3, 14'h1555, 14'h2aaa, '1, '1, 7'd64, '1));
    send_word(make_word(CMD_MAP_WR, '0, '0, '0, '0, '0, '0, 7'd0, 16'h0000));
    send_word(make_word(CMD_ADD, 15'd2, 3'd3, 14'h0000, 14'h2000, '0, '0, '0, '0));
    send_word(make_word(CMD_MAP_WR, '0, '0, '0, '0, '0, '0, 7'd64, 16'h8000));
    send_word(make_word(CMD_DEL_KEY, 15'h0000, 3'd0, '0, '0, '0, '0, '0, '0));
    send_word(make_word(CMD_MAP_WR, '0, '0, '0, '0, '0, '0, 7'd5, 16'h1234));

    random_count = defined_words;
    kind         = MIX_FILL;
    block_len    = 240;
    while (defined_words - random_count < RANDOM_WORDS) begin
      for (int i = 0; i < block_len && defined_words - random_count < RANDOM_WORDS; i++) begin
        send_word(random_word(kind));
      end
      pick = $urandom_range(0, 99);
      if (pick < 30) kind = MIX_FILL;
      else if (pick < 65) kind = MIX_BALANCED;
      else if (pick < 90) kind = MIX_DRAIN;
      else kind = MIX_NOISE;
      block_len = $urandom_range(40, 160);
    end
    in_ch.valid <= 1'b0;

    wait (words_in == words_sent && pending == 0);
    repeat (200) @(posedge clk);
    $display("Sent %0d command words, %0d of them defined commands; table peaked at %0d of %0d.",
             words_sent, defined_words, peak_fill, MAX_ENTRIES);
    $display("Adds refused on a full table: %0d; entries moved into freed slots: %0d.",
             full_refusals, slot_moves);
    if (fail_count == 0) begin
      $display("tb_top OK");
    end else begin
      $display("tb_top NOT OK");
    end
    $finish;
  end

  initial begin : watchdog
    #(LIMIT_NS);
    $display("tb_top NOT OK");
    $finish;
  end

endmodule
